// ----- rtl/bwf_pkg.sv -----
`default_nettype none

package bwf_pkg;

    // fixed point and field widths
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 12;
    localparam int SAMPLE_W  = 32;
    localparam int CUT_W     = 28;
    localparam int ORD_W     = 5;
    localparam int MAX_ORDER = 16;

    // distance path
    localparam int DSQ_W  = 2 * COORD_W + 2;
    localparam int RAD_W  = DSQ_W + 2 * FRAC_BITS;
    localparam int ROOT_W = RAD_W / 2;

    // ratio, power and gain
    localparam int QNUM_W = ROOT_W + FRAC_BITS + 1;
    localparam int QDEN_W = ROOT_W;
    localparam int POW_W  = 32;
    localparam int GDEN_W = POW_W + 1;
    localparam int GNUM_W = POW_W + 2;
    localparam int GAIN_W = FRAC_BITS + 1;
    localparam int PROD_W = SAMPLE_W + GAIN_W;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

    // register map, word index
    typedef enum logic [2:0] {
        CFG_CENTER_ROW = 3'd0,
        CFG_CENTER_COL = 3'd1,
        CFG_CUTOFF     = 3'd2,
        CFG_ORDER      = 3'd3,
        CFG_HIGH_PASS  = 3'd4
    } cfg_addr_t;

    // data carried beside the arithmetic through the pipeline
    typedef struct packed {
        logic                       kill;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } side_t;

endpackage

`default_nettype wire

// ----- rtl/bwf_sqrt.sv -----
`default_nettype none

module bwf_sqrt
    import bwf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [RAD_W-1:0]  in_rad,
    input  wire side_t             in_side,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      out_root,
    output side_t                  out_side
);

    localparam int REM_W = ROOT_W + 3;

    logic [ROOT_W:0]       vld_reg;
    logic [RAD_W-1:0]      rad_reg  [ROOT_W+1];
    logic [REM_W-1:0]      rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]     root_reg [ROOT_W+1];
    side_t                 side_reg [ROOT_W+1];
    logic                  o_valid_reg;
    logic [ROOT_W-1:0]     o_root_reg;
    side_t                 o_side_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[ROOT_W-1:0], in_valid};
            o_valid_reg <= vld_reg[ROOT_W];
        end
    end

    // capture stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg[0]  <= in_rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        logic [REM_W-1:0] t_rem;
        logic [REM_W-1:0] t_sub;
        logic             take;

        always_comb
        begin
            t_rem = {rem_reg[k][REM_W-3:0], rad_reg[k][RAD_W-1 -: 2]};
            t_sub = {1'b0, root_reg[k], 2'b01};
            take  = (t_rem >= t_sub);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[k+1]  <= rad_reg[k] << 2;
                rem_reg[k+1]  <= take ? (t_rem - t_sub) : t_rem;
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], take};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // round to nearest
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_root_reg <= (rem_reg[ROOT_W] > REM_W'(root_reg[ROOT_W])) ?
                          root_reg[ROOT_W] + 1'b1 : root_reg[ROOT_W];
            o_side_reg <= side_reg[ROOT_W];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_root  = o_root_reg;
    assign out_side  = o_side_reg;

endmodule

`default_nettype wire

// ----- rtl/bwf_div.sv -----
`default_nettype none

module bwf_div
    import bwf_pkg::*;
#(
    parameter int NUM_W = 46,
    parameter int DEN_W = 29
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] in_num,
    input  wire logic [DEN_W-1:0] in_den,
    input  wire side_t            in_side,
    output logic                  out_valid,
    output logic [NUM_W-1:0]      out_quo,
    output side_t                 out_side
);

    logic [NUM_W:0]       vld_reg;
    logic [NUM_W-1:0]     num_reg [NUM_W+1];
    logic [DEN_W-1:0]     den_reg [NUM_W+1];
    logic [DEN_W-1:0]     rem_reg [NUM_W+1];
    logic [NUM_W-1:0]     quo_reg [NUM_W+1];
    side_t                side_reg [NUM_W+1];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NUM_W-1:0], in_valid};
    end

    // capture stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            rem_reg[0]  <= '0;
            quo_reg[0]  <= '0;
            side_reg[0] <= in_side;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < NUM_W; k++)
    begin : g_step
        logic [DEN_W:0] t_rem;
        logic           take;

        always_comb
        begin
            t_rem = {rem_reg[k], num_reg[k][NUM_W-1]};
            take  = (t_rem >= {1'b0, den_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                num_reg[k+1]  <= num_reg[k] << 1;
                den_reg[k+1]  <= den_reg[k];
                rem_reg[k+1]  <= take ? DEN_W'(t_rem - {1'b0, den_reg[k]})
                                      : DEN_W'(t_rem);
                quo_reg[k+1]  <= {quo_reg[k][NUM_W-2:0], take};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[NUM_W];
    assign out_quo   = quo_reg[NUM_W];
    assign out_side  = side_reg[NUM_W];

endmodule

`default_nettype wire

// ----- rtl/bwf_power.sv -----
`default_nettype none

module bwf_power
    import bwf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic [ORD_W-1:0] order_n,
    input  wire logic             in_valid,
    input  wire logic [POW_W-1:0] in_q,
    input  wire logic             in_over,
    input  wire side_t            in_side,
    output logic                  out_valid,
    output logic [POW_W-1:0]      out_p,
    output logic                  out_over,
    output side_t                 out_side
);

    localparam int MUL_W = 2 * POW_W;

    logic [MAX_ORDER:0]   vld_reg;
    logic [POW_W-1:0]     q_reg    [MAX_ORDER+1];
    logic [POW_W-1:0]     p_reg    [MAX_ORDER+1];
    logic                 over_reg [MAX_ORDER+1];
    side_t                side_reg [MAX_ORDER+1];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[MAX_ORDER-1:0], in_valid};
    end

    // capture stage, power starts at one
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg[0]    <= in_q;
            p_reg[0]    <= POW_W'(GAIN_ONE);
            over_reg[0] <= in_over;
            side_reg[0] <= in_side;
        end
    end

    // one multiply per stage, skipped past the order or after overflow
    for (genvar k = 0; k < MAX_ORDER; k++)
    begin : g_mul
        logic [MUL_W-1:0] prod;
        logic [MUL_W-1:0] shifted;
        logic             active;

        always_comb
        begin
            prod    = MUL_W'(p_reg[k]) * MUL_W'(q_reg[k])
                      + (MUL_W'(1) << (FRAC_BITS - 1));
            shifted = prod >> FRAC_BITS;
            active  = (order_n > ORD_W'(k)) && !over_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_reg[k+1]    <= q_reg[k];
                p_reg[k+1]    <= active ? shifted[POW_W-1:0] : p_reg[k];
                over_reg[k+1] <= over_reg[k] | (active & (|shifted[MUL_W-1:POW_W]));
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[MAX_ORDER];
    assign out_p     = p_reg[MAX_ORDER];
    assign out_over  = over_reg[MAX_ORDER];
    assign out_side  = side_reg[MAX_ORDER];

endmodule

`default_nettype wire

// ----- rtl/butterworth_frequency_filter_unit.sv -----
`default_nettype none

// Butterworth gain applied to one complex frequency-domain pixel per clock.
// Each transaction on the slave stream carries a pixel's row, column and
// complex value in signed Q16.16; the master stream returns the value scaled
// by 1/(1+(dn/d0)^n) in low-pass mode or 1/(1+(d0/dn)^n) in high-pass mode,
// where dn is the distance to the configured center. One pixel enters every
// clock unless the master side stalls, and results leave in input order; the
// depth is set by the bit-per-stage square root (29 stages), the two
// bit-per-stage dividers (46 and 34 stages) and one multiply stage per
// possible order (16).
// A stall on the master side holds the whole pipeline; tready on the slave
// side is high whenever the output register is empty or being taken.
// The user must write configuration over the APB port only while the stream is idle.
module butterworth_frequency_filter_unit
    import bwf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // pixel input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,  // row[11:0], col[23:12], re_in[55:24], im_in[87:56]
    // filtered output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata   // re_out[31:0], im_out[63:32]
);

    logic [COORD_W-1:0] center_row_reg;
    logic [COORD_W-1:0] center_col_reg;
    logic [CUT_W-1:0]   cutoff_reg;
    logic [ORD_W-1:0]   order_reg;
    logic               high_pass_reg;

    logic               adv;
    logic [CUT_W-1:0]   d0;
    logic [ORD_W-1:0]   order_n;
    cfg_addr_t          waddr;

    // config write
    assign pready = 1'b1;
    assign waddr  = cfg_addr_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_row_reg <= '0;
            center_col_reg <= '0;
            cutoff_reg     <= CUT_W'(GAIN_ONE);
            order_reg      <= ORD_W'(2);
            high_pass_reg  <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (waddr)
                CFG_CENTER_ROW: center_row_reg <= pwdata[COORD_W-1:0];
                CFG_CENTER_COL: center_col_reg <= pwdata[COORD_W-1:0];
                CFG_CUTOFF:     cutoff_reg     <= pwdata[CUT_W-1:0];
                CFG_ORDER:      order_reg      <= pwdata[ORD_W-1:0];
                CFG_HIGH_PASS:  high_pass_reg  <= pwdata[0];
                default:        ;
            endcase
        end
    end

    // config read
    always_comb
    begin
        unique case (waddr)
            CFG_CENTER_ROW: prdata = 32'(center_row_reg);
            CFG_CENTER_COL: prdata = 32'(center_col_reg);
            CFG_CUTOFF:     prdata = 32'(cutoff_reg);
            CFG_ORDER:      prdata = 32'(order_reg);
            CFG_HIGH_PASS:  prdata = 32'(high_pass_reg);
            default:        prdata = '0;
        endcase
    end

    // zero cutoff acts as one step, order clamped to the deepest power stage
    assign d0      = (cutoff_reg == '0) ? CUT_W'(1) : cutoff_reg;
    assign order_n = (order_reg > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : order_reg;

    // global advance, output register frees the pipeline
    logic               m_valid_reg;
    logic [63:0]        m_data_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // stage a: coordinate differences
    logic               a_valid_reg;
    logic [COORD_W-1:0] a_dr_reg;
    logic [COORD_W-1:0] a_dc_reg;
    side_t              a_side_reg;
    logic [COORD_W-1:0] in_row;
    logic [COORD_W-1:0] in_col;

    assign in_row = s_tdata[11:0];
    assign in_col = s_tdata[23:12];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dr_reg <= (in_row >= center_row_reg) ? in_row - center_row_reg
                                                   : center_row_reg - in_row;
            a_dc_reg <= (in_col >= center_col_reg) ? in_col - center_col_reg
                                                   : center_col_reg - in_col;
            a_side_reg.kill <= 1'b0;
            a_side_reg.re   <= s_tdata[55:24];
            a_side_reg.im   <= s_tdata[87:56];
        end
    end

    // stage b: squared distance, high-pass center is forced to zero
    logic               b_valid_reg;
    logic [DSQ_W-1:0]   b_dsq_reg;
    side_t              b_side_reg;
    side_t              b_side_next;
    logic [DSQ_W-1:0]   sq_sum;

    assign sq_sum = DSQ_W'(a_dr_reg) * DSQ_W'(a_dr_reg)
                  + DSQ_W'(a_dc_reg) * DSQ_W'(a_dc_reg);

    always_comb
    begin
        b_side_next      = a_side_reg;
        b_side_next.kill = high_pass_reg && (sq_sum == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_dsq_reg  <= sq_sum;
            b_side_reg <= b_side_next;
        end
    end

    // distance in QF
    logic               sq_valid;
    logic [ROOT_W-1:0]  sq_root;
    side_t              sq_side;

    bwf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (b_valid_reg),
        .in_rad    ({b_dsq_reg, {(2 * FRAC_BITS){1'b0}}}),
        .in_side   (b_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // stage c: ratio operands with rounding offset
    logic               c_valid_reg;
    logic [QNUM_W-1:0]  c_num_reg;
    logic [QDEN_W-1:0]  c_den_reg;
    side_t              c_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (high_pass_reg)
            begin
                c_num_reg <= {2'b00, d0, {FRAC_BITS{1'b0}}} + QNUM_W'(sq_root >> 1);
                c_den_reg <= sq_root;
            end
            else
            begin
                c_num_reg <= {1'b0, sq_root, {FRAC_BITS{1'b0}}} + QNUM_W'(d0 >> 1);
                c_den_reg <= QDEN_W'(d0);
            end
            c_side_reg <= sq_side;
        end
    end

    logic               q_valid;
    logic [QNUM_W-1:0]  q_quo;
    side_t              q_side;
    side_t              q_side_in;

    assign q_side_in = c_side_reg;

    bwf_div #(
        .NUM_W (QNUM_W),
        .DEN_W (QDEN_W)
    ) u_ratio_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (c_valid_reg),
        .in_num    (c_num_reg),
        .in_den    (c_den_reg),
        .in_side   (q_side_in),
        .out_valid (q_valid),
        .out_quo   (q_quo),
        .out_side  (q_side)
    );

    // power chain
    logic               pw_valid;
    logic [POW_W-1:0]   pw_p;
    logic               pw_over;
    side_t              pw_side;

    bwf_power u_power (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .order_n   (order_n),
        .in_valid  (q_valid),
        .in_q      (q_quo[POW_W-1:0]),
        .in_over   (|q_quo[QNUM_W-1:POW_W]),
        .in_side   (q_side),
        .out_valid (pw_valid),
        .out_p     (pw_p),
        .out_over  (pw_over),
        .out_side  (pw_side)
    );

    // stage e: gain operands, saturated power kills the gain
    logic               e_valid_reg;
    logic [GNUM_W-1:0]  e_num_reg;
    logic [GDEN_W-1:0]  e_den_reg;
    side_t              e_side_reg;
    side_t              e_side_next;
    logic [GDEN_W-1:0]  g_den;

    assign g_den = GDEN_W'(GAIN_ONE) + GDEN_W'(pw_p);

    always_comb
    begin
        e_side_next      = pw_side;
        e_side_next.kill = pw_side.kill | pw_over;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_den_reg  <= g_den;
            e_num_reg  <= (GNUM_W'(1) << (2 * FRAC_BITS)) + GNUM_W'(g_den >> 1);
            e_side_reg <= e_side_next;
        end
    end

    logic               g_valid;
    logic [GNUM_W-1:0]  g_quo;
    side_t              g_side;

    bwf_div #(
        .NUM_W (GNUM_W),
        .DEN_W (GDEN_W)
    ) u_gain_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (e_valid_reg),
        .in_num    (e_num_reg),
        .in_den    (e_den_reg),
        .in_side   (e_side_reg),
        .out_valid (g_valid),
        .out_quo   (g_quo),
        .out_side  (g_side)
    );

    // stage f: final gain and sample magnitudes
    logic                f_valid_reg;
    logic [GAIN_W-1:0]   f_gain_reg;
    logic [SAMPLE_W-1:0] f_mag_re_reg;
    logic [SAMPLE_W-1:0] f_mag_im_reg;
    logic                f_neg_re_reg;
    logic                f_neg_im_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_gain_reg   <= g_side.kill ? '0 : g_quo[GAIN_W-1:0];
            f_neg_re_reg <= g_side.re[SAMPLE_W-1];
            f_neg_im_reg <= g_side.im[SAMPLE_W-1];
            f_mag_re_reg <= g_side.re[SAMPLE_W-1] ? SAMPLE_W'(-g_side.re) : g_side.re;
            f_mag_im_reg <= g_side.im[SAMPLE_W-1] ? SAMPLE_W'(-g_side.im) : g_side.im;
        end
    end

    // stage g: scale multiplies
    logic                g_valid_reg;
    logic [PROD_W-1:0]   g_prod_re_reg;
    logic [PROD_W-1:0]   g_prod_im_reg;
    logic                g_neg_re_reg;
    logic                g_neg_im_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_prod_re_reg <= PROD_W'(f_mag_re_reg) * PROD_W'(f_gain_reg);
            g_prod_im_reg <= PROD_W'(f_mag_im_reg) * PROD_W'(f_gain_reg);
            g_neg_re_reg  <= f_neg_re_reg;
            g_neg_im_reg  <= f_neg_im_reg;
        end
    end

    // output: round magnitude, restore sign
    logic [PROD_W-1:0]   rnd_re;
    logic [PROD_W-1:0]   rnd_im;
    logic [SAMPLE_W-1:0] mag_re_out;
    logic [SAMPLE_W-1:0] mag_im_out;

    always_comb
    begin
        rnd_re     = g_prod_re_reg + (PROD_W'(1) << (FRAC_BITS - 1));
        rnd_im     = g_prod_im_reg + (PROD_W'(1) << (FRAC_BITS - 1));
        mag_re_out = rnd_re[FRAC_BITS +: SAMPLE_W];
        mag_im_out = rnd_im[FRAC_BITS +: SAMPLE_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_data_reg[31:0]  <= g_neg_re_reg ? SAMPLE_W'(-mag_re_out) : mag_re_out;
            m_data_reg[63:32] <= g_neg_im_reg ? SAMPLE_W'(-mag_im_out) : mag_im_out;
        end
    end

    // valid bits of the local stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= sq_valid;
            e_valid_reg <= pw_valid;
            f_valid_reg <= g_valid;
            g_valid_reg <= f_valid_reg;
            m_valid_reg <= g_valid_reg;
        end
    end

    // gain never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        f_valid_reg |-> (f_gain_reg <= GAIN_ONE))
        else $error("gain above one");

    // a stall freezes the stage valid bits
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({a_valid_reg, b_valid_reg, c_valid_reg, e_valid_reg,
                          f_valid_reg, g_valid_reg}))
        else $error("pipeline moved during stall");

    // an idle input cycle enters the pipeline as a bubble
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && !s_tvalid |=> !a_valid_reg)
        else $error("bubble became valid");

endmodule

`default_nettype wire
